// File: design/mpcn_pkg.sv
// ----------------------------------------------------------------------------
// mpcn_pkg
// Shared types and constants for the motif profile count normalizer.
// ----------------------------------------------------------------------------
package mpcn_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_NORM   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH       = 2'd0;
    localparam logic [1:0] REG_PALINDROMIC = 2'd1;
    localparam logic [1:0] REG_PSEUDOCOUNT = 2'd2;

    // configuration reset values
    localparam logic [5:0]  RST_WIDTH       = 6'd8;
    localparam logic [15:0] RST_PSEUDOCOUNT = 16'd64;

    // nucleotide codes, highest valid code is T
    localparam logic [2:0] BASE_T = 3'd3;

    localparam int ALPHABET_SIZE = 4;
    localparam int RESULT_LIMIT  = 32;

    // quotient bits of one probability (one more than Q0.16 for saturation)
    localparam int QUOT_BITS = 17;
    localparam logic [4:0] DIV_LAST_STEP = 5'(QUOT_BITS - 1);

    // probability used when a column sum is zero (one quarter)
    localparam logic [15:0] PROB_QUARTER = 16'd16384;
    localparam logic [15:0] PROB_MAX     = 16'hFFFF;

    // controller to datapath command group
    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic       clear;
        logic       add_op;
        logic [1:0] base;
        logic       latch_p;
        logic       pooled;
        logic       term;
        logic       sum;
        logic       div_init;
        logic       div_step;
        logic       load_out;
        logic [4:0] col;
        logic       last;
    } mpcn_cmd_t;

endpackage

// File: design/mpcn_if.sv
// ----------------------------------------------------------------------------
// mpcn_in_if / mpcn_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mpcn_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [4:0] column;
    logic [2:0] base;

    modport source (output valid, command, column, base, input ready);
    modport sink   (input valid, command, column, base, output ready);
endinterface

interface mpcn_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  out_column;
    logic [15:0] prob_a;
    logic [15:0] prob_c;
    logic [15:0] prob_g;
    logic [15:0] prob_t;
    logic        last_column;

    modport source (output valid, out_column, prob_a, prob_c, prob_g, prob_t, last_column,
                    input ready);
    modport sink   (input valid, out_column, prob_a, prob_c, prob_g, prob_t, last_column,
                    output ready);
endinterface

// File: design/mpcn_datapath.sv
// ----------------------------------------------------------------------------
// mpcn_datapath
// Count memory, pooled term and column sum, four restoring dividers and
// the result register.
// ----------------------------------------------------------------------------
module mpcn_datapath
    import mpcn_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int COUNT_BITS  = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  mpcn_cmd_t                      cmd,
    input  logic [$clog2(MAX_COLUMNS)-1:0] addr,
    input  logic [15:0]                    pseudocount,
    output logic [4:0]                     out_column,
    output logic [15:0]                    prob_a,
    output logic [15:0]                    prob_c,
    output logic [15:0]                    prob_g,
    output logic [15:0]                    prob_t,
    output logic                           last_column
);

    localparam int PW = COUNT_BITS + 1;
    localparam int VW = COUNT_BITS + 10;
    localparam int SW = VW + 2;
    localparam int NW = SW + 16;

    typedef logic [ALPHABET_SIZE-1:0][COUNT_BITS-1:0] row_t;

    row_t                   mem [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] row_valid_reg;
    row_t                   rd_data_reg;
    logic                   rd_hit_reg;
    row_t                   row_cur;
    row_t                   row_new;
    row_t                   rowp_reg;

    logic [VW-1:0]        v_reg    [ALPHABET_SIZE];
    logic [VW-1:0]        v_next   [ALPHABET_SIZE];
    logic [SW-1:0]        sum_reg;
    logic [SW-1:0]        rem_reg  [ALPHABET_SIZE];
    logic [SW-1:0]        rem_next [ALPHABET_SIZE];
    logic [QUOT_BITS-1:0] lo_reg   [ALPHABET_SIZE];
    logic [QUOT_BITS-1:0] lo_next  [ALPHABET_SIZE];
    logic [QUOT_BITS-1:0] quo_reg  [ALPHABET_SIZE];
    logic [QUOT_BITS-1:0] quo_next [ALPHABET_SIZE];
    logic [15:0]          prob     [ALPHABET_SIZE];

    logic [4:0]  col_reg;
    logic        last_reg;
    logic [15:0] prob_reg [ALPHABET_SIZE];

    // rows never written since reset or clear read as zero
    assign row_cur = rd_hit_reg ? rd_data_reg : '0;

    // saturating update of one counter
    always_comb
    begin
        row_new = row_cur;
        if (cmd.add_op)
        begin
            if (row_cur[cmd.base] != '1)
                row_new[cmd.base] = row_cur[cmd.base] + 1'b1;
        end
        else
        begin
            if (row_cur[cmd.base] != '0)
                row_new[cmd.base] = row_cur[cmd.base] - 1'b1;
        end
    end

    // count memory, one port read and write
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[addr] <= row_new;
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr];
            rd_hit_reg  <= row_valid_reg[addr];
        end
    end

    // row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_valid_reg <= '0;
        else if (cmd.clear)
            row_valid_reg <= '0;
        else if (cmd.wr_en)
            row_valid_reg[addr] <= 1'b1;
    end

    // pooled terms, divider steps and result selection
    always_comb
    begin
        logic [PW-1:0]   c;
        logic [NW-1:0]   n;
        logic [SW:0]     t;
        for (int b = 0; b < ALPHABET_SIZE; b++)
        begin
            n = '0;
            t = '0;
            c = PW'(rowp_reg[b]);
            if (cmd.pooled)
                c = c + PW'(row_cur[ALPHABET_SIZE-1-b]);
            v_next[b] = (VW'(c) << 8) + VW'(pseudocount);

            rem_next[b] = rem_reg[b];
            lo_next[b]  = lo_reg[b];
            quo_next[b] = quo_reg[b];
            if (cmd.div_init)
            begin
                n = (NW'(v_reg[b]) << 16) + NW'(sum_reg >> 1);
                rem_next[b] = SW'(n >> QUOT_BITS);
                lo_next[b]  = n[QUOT_BITS-1:0];
                quo_next[b] = '0;
            end
            else
            begin
                t = {rem_reg[b], lo_reg[b][QUOT_BITS-1]};
                lo_next[b] = lo_reg[b] << 1;
                if (t >= {1'b0, sum_reg})
                begin
                    rem_next[b] = SW'(t - {1'b0, sum_reg});
                    quo_next[b] = {quo_reg[b][QUOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[b] = t[SW-1:0];
                    quo_next[b] = {quo_reg[b][QUOT_BITS-2:0], 1'b0};
                end
            end

            if (sum_reg == '0)
                prob[b] = PROB_QUARTER;
            else if (quo_reg[b][QUOT_BITS-1])
                prob[b] = PROB_MAX;
            else
                prob[b] = quo_reg[b][15:0];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_p)
            rowp_reg <= row_cur;
        if (cmd.term)
            v_reg <= v_next;
        if (cmd.sum)
            sum_reg <= SW'(v_reg[0]) + SW'(v_reg[1]) + SW'(v_reg[2]) + SW'(v_reg[3]);
        if (cmd.div_init || cmd.div_step)
        begin
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
            quo_reg <= quo_next;
        end
        if (cmd.load_out)
        begin
            col_reg  <= cmd.col;
            last_reg <= cmd.last;
            prob_reg <= prob;
        end
    end

    assign out_column  = col_reg;
    assign last_column = last_reg;
    assign prob_a      = prob_reg[0];
    assign prob_c      = prob_reg[1];
    assign prob_g      = prob_reg[2];
    assign prob_t      = prob_reg[3];

endmodule

// File: design/mpcn_controller.sv
// ----------------------------------------------------------------------------
// mpcn_controller
// Sequencer for counter updates and the column-by-column normalize run.
// ----------------------------------------------------------------------------
module mpcn_controller
    import mpcn_pkg::*;
#(
    parameter int MAX_COLUMNS = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     command,
    input  logic [4:0]                     column,
    input  logic [2:0]                     base,
    output logic                           out_valid,
    input  logic                           out_ready,
    input  logic [5:0]                     width_cfg,
    input  logic                           palindromic_mode,
    output mpcn_cmd_t                      cmd,
    output logic [$clog2(MAX_COLUMNS)-1:0] addr
);

    localparam int AB    = $clog2(MAX_COLUMNS);
    localparam int LIMIT = (MAX_COLUMNS < RESULT_LIMIT) ? MAX_COLUMNS : RESULT_LIMIT;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD_WR,
        ST_RD_P,
        ST_RD_Q,
        ST_TERM,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] p_reg, p_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       ovalid_reg, ovalid_next;
    logic [4:0] ucol_reg, ucol_next;
    logic [1:0] ubase_reg, ubase_next;
    logic       uadd_reg, uadd_next;
    logic [5:0] w;
    logic [5:0] q;
    logic       accept;

    // columns in use
    always_comb
    begin
        if (width_cfg == '0)
            w = 6'd1;
        else if (width_cfg > 6'(LIMIT))
            w = 6'(LIMIT);
        else
            w = width_cfg;
    end

    assign q        = w - 6'd1 - p_reg;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_valid = ovalid_reg;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        p_next      = p_reg;
        cnt_next    = cnt_reg;
        ucol_next   = ucol_reg;
        ubase_next  = ubase_reg;
        uadd_next   = uadd_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        cmd.add_op  = uadd_reg;
        cmd.base    = ubase_reg;
        cmd.col     = p_reg[4:0];
        cmd.last    = (p_reg == w - 6'd1);
        cmd.pooled  = palindromic_mode && (q != p_reg);
        addr        = AB'(ucol_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_ADD, CMD_REMOVE:
                        begin
                            if ({1'b0, column} < w && base <= BASE_T)
                            begin
                                cmd.rd_en  = 1'b1;
                                addr       = AB'(column);
                                ucol_next  = column;
                                ubase_next = base[1:0];
                                uadd_next  = (command == CMD_ADD);
                                state_next = ST_UPD_WR;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        CMD_NORM:
                        begin
                            p_next     = '0;
                            state_next = ST_RD_P;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_UPD_WR:
            begin
                cmd.wr_en  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD_P:
            begin
                cmd.rd_en  = 1'b1;
                addr       = AB'(p_reg);
                state_next = ST_RD_Q;
            end
            ST_RD_Q:
            begin
                cmd.latch_p = 1'b1;
                cmd.rd_en   = 1'b1;
                addr        = AB'(q);
                state_next  = ST_TERM;
            end
            ST_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST_STEP)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    ovalid_next  = 1'b1;
                    if (p_reg == w - 6'd1)
                        state_next = ST_IDLE;
                    else
                    begin
                        p_next     = p_reg + 6'd1;
                        state_next = ST_RD_P;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            p_reg      <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            ucol_reg   <= '0;
            ubase_reg  <= '0;
            uadd_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            p_reg      <= p_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
            ucol_reg   <= ucol_next;
            ubase_reg  <= ubase_next;
            uadd_reg   <= uadd_next;
        end
    end

endmodule

// File: design/motif_profile_count_normalizer.sv
// Add and remove each read the memory, then write back; clear acts in the cycle it is accepted.
// Normalize emits one result per column in use; while the result register is
// free, each column takes two row reads, term and sum stages, then 17 steps
// of the four restoring dividers, which set the rate of a normalize run.
// Reset clears control state, configuration and all counters at once through
// per-column valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
// motif_profile_count_normalizer
// Motif count matrix with saturating updates and pseudocount normalization.
// ----------------------------------------------------------------------------
module motif_profile_count_normalizer
    import mpcn_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int COUNT_BITS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    mpcn_in_if.sink     items,
    mpcn_out_if.source  results,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [5:0]  width_reg;
    logic        palin_reg;
    logic [15:0] pseudo_reg;
    mpcn_cmd_t   cmd;
    logic [$clog2(MAX_COLUMNS)-1:0] addr;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            palin_reg  <= 1'b0;
            pseudo_reg <= RST_PSEUDOCOUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:       width_reg  <= cfg_data[5:0];
                REG_PALINDROMIC: palin_reg  <= cfg_data[0];
                REG_PSEUDOCOUNT: pseudo_reg <= cfg_data;
                default:         width_reg  <= width_reg;
            endcase
        end
    end

    mpcn_controller #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (items.valid),
        .in_ready         (items.ready),
        .command          (items.command),
        .column           (items.column),
        .base             (items.base),
        .out_valid        (results.valid),
        .out_ready        (results.ready),
        .width_cfg        (width_reg),
        .palindromic_mode (palin_reg),
        .cmd              (cmd),
        .addr             (addr)
    );

    mpcn_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .addr        (addr),
        .pseudocount (pseudo_reg),
        .out_column  (results.out_column),
        .prob_a      (results.prob_a),
        .prob_c      (results.prob_c),
        .prob_g      (results.prob_g),
        .prob_t      (results.prob_t),
        .last_column (results.last_column)
    );

endmodule

// File: design/mpcn_checker.sv
// ----------------------------------------------------------------------------
// mpcn_checker
// Port-level checks of the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module mpcn_checker
    import mpcn_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] command,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] out_column,
    input logic       last_column
);

    // a waiting result beat holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_column))
        else $error("result beat dropped or changed while stalled");

    // a normalize run blocks new items
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_NORM |=> !in_ready)
        else $error("item taken during normalize run");

    // clear leaves the item channel ready in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_CLEAR |=> in_ready)
        else $error("clear did not return to idle");

    // a run starts at column zero after its last column
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_column ##1 out_valid && out_ready
            |-> out_column == 5'd0 || !$past(in_ready))
        else $error("result beat after last column out of order");

endmodule

bind motif_profile_count_normalizer mpcn_checker u_mpcn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (items.valid),
    .in_ready    (items.ready),
    .command     (items.command),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_column  (results.out_column),
    .last_column (results.last_column)
);

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motif profile count normalizer testbench
// Drives count updates, clears and normalize commands through the item
// channel, predicts every column result from a local count matrix and
// compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb;
    import mpcn_pkg::*;

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] column;
        logic [2:0] base;
    } item_t;

    typedef struct packed {
        logic [4:0]  out_column;
        logic [15:0] prob_a;
        logic [15:0] prob_c;
        logic [15:0] prob_g;
        logic [15:0] prob_t;
        logic        last_column;
    } column_prob_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    mpcn_in_if  items ();
    mpcn_out_if results ();

    motif_profile_count_normalizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items.sink),
        .results   (results.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [15:0]  counts [32][4];
    logic [5:0]   width_reg;
    logic         palin_reg;
    logic [15:0]  pseudo_reg;

    item_t        pending_items [$];
    column_prob_t expected_probs [$];
    int           mismatches;
    int           cycles;
    int           hold_off;
    bit           in_accepted;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 5000000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [15:0] quantize(logic [63:0] v, logic [63:0] total);
        logic [63:0] q;
        if (total == 0)
            return 16'd16384;
        q = (v * 64'd65536 + total / 2) / total;
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    // apply one accepted beat to the count matrix, queue column results
    task automatic predict_counts(item_t it);
        int w;
        int q;
        logic [63:0] v [4];
        logic [63:0] total;
        logic [63:0] c;
        column_prob_t r;
        w = (width_reg < 1) ? 1 : ((width_reg > 32) ? 32 : int'(width_reg));
        case (it.command)
            CMD_ADD, CMD_REMOVE:
            begin
                if (it.column < w && it.base <= BASE_T)
                begin
                    if (it.command == CMD_ADD)
                    begin
                        if (counts[it.column][it.base] != 16'hFFFF)
                            counts[it.column][it.base]++;
                    end
                    else if (counts[it.column][it.base] != 0)
                        counts[it.column][it.base]--;
                end
            end
            CMD_CLEAR:
            begin
                foreach (counts[i, j]) counts[i][j] = '0;
            end
            default:
            begin
                for (int p = 0; p < w; p++)
                begin
                    q = w - 1 - p;
                    total = 0;
                    for (int b = 0; b < 4; b++)
                    begin
                        c = counts[p][b];
                        if (palin_reg && q != p)
                            c += counts[q][3 - b];
                        v[b] = (c << 8) + pseudo_reg;
                        total += v[b];
                    end
                    r.out_column  = p[4:0];
                    r.prob_a      = quantize(v[0], total);
                    r.prob_c      = quantize(v[1], total);
                    r.prob_g      = quantize(v[2], total);
                    r.prob_t      = quantize(v[3], total);
                    r.last_column = (p == w - 1);
                    expected_probs.push_back(r);
                end
            end
        endcase
    endtask

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // input handshake seen at the last rising edge
    always @(posedge clk)
    begin
        in_accepted <= rst_n && items.valid && items.ready;
    end

    // driver: offers queued items with random gaps, inputs change on falling edge
    int send_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items.valid   <= 1'b0;
            items.command <= '0;
            items.column  <= '0;
            items.base    <= '0;
            send_gap      <= 0;
        end
        else if (items.valid && !in_accepted)
        begin
            // hold the beat until it is taken
        end
        else if (send_gap > 0)
        begin
            items.valid <= 1'b0;
            send_gap    <= send_gap - 1;
        end
        else if (pending_items.size() > 0)
        begin
            item_t it;
            it = pending_items.pop_front();
            items.valid   <= 1'b1;
            items.command <= it.command;
            items.column  <= it.column;
            items.base    <= it.base;
            send_gap      <= gap_len();
        end
        else
            items.valid <= 1'b0;
    end

    // prediction of accepted input beats
    always @(posedge clk)
    begin
        if (rst_n && items.valid && items.ready)
            predict_counts('{items.command, items.column, items.base});
    end

    // receiver ready, with random stalls and a long hold-off on request
    int stall;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            stall         <= 0;
        end
        else if (hold_off > 0)
            results.ready <= 1'b0;
        else if (stall > 0)
        begin
            results.ready <= 1'b0;
            stall         <= stall - 1;
        end
        else
        begin
            results.ready <= 1'b1;
            stall         <= gap_len();
        end
    end

    // long hold-off counter
    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            column_prob_t got;
            column_prob_t want;
            got = '{results.out_column, results.prob_a, results.prob_c,
                    results.prob_g, results.prob_t, results.last_column};
            if (expected_probs.size() == 0)
            begin
                $display("%0t unexpected result beat: actual %p", $time, got);
                mismatches++;
            end
            else
            begin
                want = expected_probs.pop_front();
                if (got !== want)
                begin
                    $display("%0t result mismatch: expected %p actual %p",
                             $time, want, got);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_WIDTH:       width_reg  = val[5:0];
            REG_PALINDROMIC: palin_reg  = val[0];
            default:         pseudo_reg = val;
        endcase
    endtask

    // wait until every queued beat is taken and every result has come
    task automatic drain();
        while (pending_items.size() > 0 || items.valid || expected_probs.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic item_t rand_item();
        item_t it;
        int k;
        k = $urandom_range(0, 99);
        it.column = 5'($urandom_range(0, 31));
        it.base   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                : 3'($urandom_range(0, 3));
        if (k < 55)      it.command = CMD_ADD;
        else if (k < 80) it.command = CMD_REMOVE;
        else if (k < 83) it.command = CMD_CLEAR;
        else             it.command = CMD_NORM;
        if (it.command == CMD_NORM && $urandom_range(0, 3) != 0)
            it.command = CMD_ADD;
        return it;
    endfunction

    initial
    begin
        mismatches    = 0;
        cycles        = 0;
        hold_off      = 0;
        cfg_we        = 1'b0;
        cfg_index     = REG_WIDTH;
        cfg_data      = '0;
        width_reg     = RST_WIDTH;
        palin_reg     = 1'b0;
        pseudo_reg    = RST_PSEUDOCOUNT;
        foreach (counts[i, j]) counts[i][j] = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, remove at zero, ignored beats
        pending_items.push_back('{CMD_NORM, 5'd0, 3'd0});
        pending_items.push_back('{CMD_REMOVE, 5'd0, 3'd0});
        pending_items.push_back('{CMD_ADD, 5'd7, BASE_T});
        pending_items.push_back('{CMD_ADD, 5'd8, 3'd0});
        pending_items.push_back('{CMD_ADD, 5'd31, 3'd1});
        pending_items.push_back('{CMD_ADD, 5'd0, 3'd7});
        pending_items.push_back('{CMD_ADD, 5'd0, 3'd4});
        pending_items.push_back('{CMD_ADD, 5'd1, 3'd2});
        pending_items.push_back('{CMD_NORM, 5'd31, 3'd7});
        drain();

        // widest, palindromic, zero pseudocount
        write_reg(REG_WIDTH, 16'd32);
        write_reg(REG_PALINDROMIC, 16'd1);
        write_reg(REG_PSEUDOCOUNT, 16'd0);
        pending_items.push_back('{CMD_ADD, 5'd31, 3'd0});
        pending_items.push_back('{CMD_ADD, 5'd0, 3'd2});
        pending_items.push_back('{CMD_NORM, 5'd0, 3'd0});
        pending_items.push_back('{CMD_CLEAR, 5'd0, 3'd0});
        pending_items.push_back('{CMD_NORM, 5'd0, 3'd0});
        drain();

        // width zero clamps to one, odd width middle column, max pseudocount
        write_reg(REG_WIDTH, 16'd0);
        write_reg(REG_PSEUDOCOUNT, 16'hFFFF);
        pending_items.push_back('{CMD_ADD, 5'd0, 3'd3});
        pending_items.push_back('{CMD_NORM, 5'd0, 3'd0});
        drain();
        write_reg(REG_WIDTH, 16'd63);
        write_reg(REG_WIDTH, 16'd5);
        pending_items.push_back('{CMD_ADD, 5'd2, 3'd1});
        pending_items.push_back('{CMD_ADD, 5'd4, 3'd0});
        pending_items.push_back('{CMD_NORM, 5'd0, 3'd0});
        drain();

        // repeated updates on a narrow width
        write_reg(REG_WIDTH, 16'd2);
        write_reg(REG_PALINDROMIC, 16'd0);
        write_reg(REG_PSEUDOCOUNT, 16'd1);
        repeat (3) pending_items.push_back('{CMD_ADD, 5'd1, 3'd2});
        pending_items.push_back('{CMD_NORM, 5'd0, 3'd0});
        drain();

        // random phases across several settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_WIDTH, 16'($urandom_range(0, 63)));
            write_reg(REG_PALINDROMIC, 16'($urandom_range(0, 1)));
            write_reg(REG_PSEUDOCOUNT, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                  : 16'($urandom_range(0, 512)));
            for (int n = 0; n < 50; n++)
                pending_items.push_back(rand_item());
            // a closing normalize run per phase; in phase two, twenty more under a long receiver hold-off
            pending_items.push_back('{CMD_NORM, 5'($urandom), 3'($urandom)});
            if (ph == 2)
            begin
                repeat (20) pending_items.push_back('{CMD_NORM, 5'd0, 3'd0});
                hold_off = 3000;
            end
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
